/* rtl/bsu_pkg.sv */
`timescale 1ns / 1ps

package bsu_pkg;

  localparam int unsigned ValW      = 8;
  localparam int unsigned NumValues = 256;
  localparam int unsigned CntW      = 13;
  localparam int unsigned Capacity  = 4096;

  localparam logic FuncStore = 1'b0;
  localparam logic FuncTake  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STORE,
    S_SCAN,
    S_EMPTY
  } state_e;

endpackage

/* rtl/byte_sorter_unit.sv */
`timescale 1ns / 1ps
// Store: histogram write-back in the cycle after the transfer, then idle for the next one.
// Take: the cursor scans past zero-count entries (one RAM read per cycle), then loads the
// result register once the output is free; over a whole drain it skips at most 255 entries.
// Empty-store take: result loaded when output is free; next transfer in the cycle after a load.
// Reset (async, active low) clears control, totals, cursor, overflow flag and the
// per-entry valid bits, so every histogram entry reads zero at once after reset.

module byte_sorter_unit #(
  parameter int unsigned CAPACITY = bsu_pkg::Capacity
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [bsu_pkg::ValW-1:0] data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [bsu_pkg::ValW-1:0] sorted_byte_o,
  output logic                     valid_res_o,
  output logic                     is_last_o,
  output logic                     overflow_o
);

  localparam int unsigned ValW = bsu_pkg::ValW;
  localparam int unsigned CntW = bsu_pkg::CntW;

  bsu_pkg::state_e state_q, state_d;

  logic [CntW-1:0]              total_q, total_d;
  logic [ValW-1:0]              cursor_q, cursor_d;
  logic [ValW-1:0]              byte_q, byte_d;
  logic                         ovf_q, ovf_d;
  logic [bsu_pkg::NumValues-1:0] vld_q;
  logic                         vld_rd_q;

  logic                         out_valid_q, out_valid_d;
  logic [ValW-1:0]              out_byte_q, out_byte_d;
  logic                         out_res_q, out_res_d;
  logic                         out_last_q, out_last_d;
  logic                         out_ovf_q, out_ovf_d;
  logic                         out_load;

  logic                         ram_we, ram_re;
  logic [ValW-1:0]              ram_waddr, ram_raddr;
  logic [CntW-1:0]              ram_wdata, ram_rdata;
  logic [CntW-1:0]              count_rd;
  logic                         out_free;
  logic                         full;

  bsu_ram #(
    .Width(CntW),
    .Depth(bsu_pkg::NumValues)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign count_rd = vld_rd_q ? ram_rdata : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = total_q >= CntW'(CAPACITY);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == bsu_pkg::FuncTake) begin
            state_d = (total_q == '0) ? bsu_pkg::S_EMPTY : bsu_pkg::S_SCAN;
          end else if (!full) begin
            state_d = bsu_pkg::S_STORE;
          end
        end
      end
      bsu_pkg::S_STORE: state_d = bsu_pkg::S_IDLE;
      bsu_pkg::S_SCAN: begin
        if (count_rd != '0 && out_free) begin
          state_d = bsu_pkg::S_IDLE;
        end
      end
      bsu_pkg::S_EMPTY: begin
        if (out_free) begin
          state_d = bsu_pkg::S_IDLE;
        end
      end
      default: state_d = bsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = cursor_q;
    ram_raddr  = cursor_q;
    ram_wdata  = count_rd;
    total_d    = total_q;
    cursor_d   = cursor_q;
    byte_d     = byte_q;
    ovf_d      = ovf_q;
    out_load   = 1'b0;
    out_byte_d = '0;
    out_res_d  = 1'b0;
    out_last_d = 1'b0;
    out_ovf_d  = ovf_q;
    unique case (state_q)
      bsu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == bsu_pkg::FuncTake) begin
            if (total_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = cursor_q;
            end
          end else if (full) begin
            ovf_d = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = data_byte_i;
            byte_d    = data_byte_i;
          end
        end
      end
      bsu_pkg::S_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = byte_q;
        ram_wdata = count_rd + CntW'(1);
        total_d   = total_q + CntW'(1);
        if (byte_q < cursor_q) begin
          cursor_d = byte_q;
        end
      end
      bsu_pkg::S_SCAN: begin
        if (count_rd != '0) begin
          if (out_free) begin
            ram_we     = 1'b1;
            ram_waddr  = cursor_q;
            ram_wdata  = count_rd - CntW'(1);
            total_d    = total_q - CntW'(1);
            out_load   = 1'b1;
            out_byte_d = cursor_q;
            out_res_d  = 1'b1;
            out_last_d = (total_q == CntW'(1));
          end
        end else begin
          cursor_d  = cursor_q + ValW'(1);
          ram_re    = 1'b1;
          ram_raddr = cursor_q + ValW'(1);
        end
      end
      bsu_pkg::S_EMPTY: begin
        out_load = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsu_pkg::S_IDLE;
      total_q     <= '0;
      cursor_q    <= '0;
      ovf_q       <= 1'b0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cursor_q    <= cursor_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= vld_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_res_q  <= out_res_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sorted_byte_o = out_byte_q;
  assign valid_res_o   = out_res_q;
  assign is_last_o     = out_last_q;
  assign overflow_o    = out_ovf_q;

  a_last_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> valid_res_o)
    else $error("last flag on a result without a byte");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> sorted_byte_o == '0)
    else $error("nonzero byte on an empty result");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsu_pkg::S_SCAN |-> total_q != '0)
    else $error("cursor scan with an empty store");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("histogram read and write in the same cycle");

endmodule

/* rtl/bsu_ram.sv */
`timescale 1ns / 1ps

module bsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ValW      = bsu_pkg::ValW;
  localparam int unsigned CntW      = bsu_pkg::CntW;
  localparam int unsigned NumValues = bsu_pkg::NumValues;

  typedef struct packed {
    logic [ValW-1:0] sorted_byte;
    logic            valid_res;
    logic            is_last;
    logic            overflow;
  } pick_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic            func_i;
  logic [ValW-1:0] data_byte_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [ValW-1:0] sorted_byte_o;
  logic            valid_res_o;
  logic            is_last_o;
  logic            overflow_o;

  logic [CntW-1:0] byte_hist [NumValues];
  logic [CntW-1:0] held_count;
  logic [ValW-1:0] scan_ptr;
  logic            overflow_flag;
  pick_t           expected_picks [$];

  int  mismatches;
  int  items_sent;
  int  ready_hold;
  bit  quiet;

  byte_sorter_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sorted_byte_o(sorted_byte_o),
    .valid_res_o  (valid_res_o),
    .is_last_o    (is_last_o),
    .overflow_o   (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void predict_op(logic f, logic [ValW-1:0] b);
    pick_t           p;
    logic [ValW-1:0] v;
    if (f == bsu_pkg::FuncStore) begin
      if (held_count >= bsu_pkg::Capacity) begin
        overflow_flag = 1'b1;
      end else begin
        byte_hist[b] = byte_hist[b] + 1'b1;
        held_count   = held_count + 1'b1;
        if (b < scan_ptr) scan_ptr = b;
      end
      return;
    end
    p = '0;
    p.overflow = overflow_flag;
    if (held_count != 0) begin
      v = scan_ptr;
      for (int i = 0; i < NumValues && byte_hist[v] == 0; i++) v = v + 1'b1;
      scan_ptr     = v;
      byte_hist[v] = byte_hist[v] - 1'b1;
      held_count   = held_count - 1'b1;
      p.sorted_byte = v;
      p.valid_res   = 1'b1;
      p.is_last     = (held_count == 0);
    end
    expected_picks.push_back(p);
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    if (mismatches < 10)
      $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_picks
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_picks.size() == 0) begin
        note_mismatch("unexpected result, sorted_byte", -1, int'(sorted_byte_o));
      end else begin
        want = expected_picks.pop_front();
        if (sorted_byte_o !== want.sorted_byte)
          note_mismatch("sorted_byte", int'(want.sorted_byte), int'(sorted_byte_o));
        if (valid_res_o !== want.valid_res)
          note_mismatch("valid_res", int'(want.valid_res), int'(valid_res_o));
        if (is_last_o !== want.is_last)
          note_mismatch("is_last", int'(want.is_last), int'(is_last_o));
        if (overflow_o !== want.overflow)
          note_mismatch("overflow", int'(want.overflow), int'(overflow_o));
      end
    end
  end

  // hold off when asked, else stall at random
  initial begin : drive_ready
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        ready_hold--;
      end else if (stall_left > 0 && !quiet) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_op(logic f, logic [ValW-1:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i  <= 1'b0;
      func_i      <= 1'($urandom_range(0, 1));
      data_byte_i <= ValW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_op(f, b);
    items_sent++;
  endtask

  task automatic store(logic [ValW-1:0] b);
    send_op(bsu_pkg::FuncStore, b);
  endtask

  task automatic take();
    send_op(bsu_pkg::FuncTake, ValW'($urandom));
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    take();
    store(8'h00);
    store(8'hff);
    store(8'hff);
    store(8'h80);
    store(8'h00);
    repeat (5) take();
    take();
    store(8'd200);
    send_op(bsu_pkg::FuncTake, 8'hff);
    store(8'd200);
    store(8'd10);
    take();
    take();
    store(8'h55);
    store(8'haa);
    take();
    take();
    take();
    wait_results();
  endtask

  task automatic test_random_sequences();
    int kind;
    int n;
    int lo;
    int hi;
    while (items_sent < 1500) begin
      kind  = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 4) == 0);
      if (held_count > 3000) kind = 9;
      if (kind <= 5) begin
        n  = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
        lo = $urandom_range(0, 255);
        hi = ($urandom_range(0, 2) == 0) ? lo + $urandom_range(0, 3)
                                         : $urandom_range(lo, 255);
        if (hi > 255) hi = 255;
        repeat (n) store(ValW'($urandom_range(lo, hi)));
        repeat (n + $urandom_range(0, 1)) take();
      end else if (kind <= 7) begin
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(0, 2) == 0) take();
          else store(ValW'($urandom));
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 12))
          send_op(1'($urandom_range(0, 1)), ValW'($urandom));
      end else begin
        repeat (held_count + 1) take();
      end
    end
    quiet = 1'b0;
    wait_results();
  endtask

  task automatic test_backpressure();
    ready_hold = 400;
    repeat (10) store(ValW'($urandom));
    repeat (10) take();
    repeat (5) store(ValW'($urandom));
    repeat (6) take();
    wait_results();
  endtask

  initial begin
    for (int i = 0; i < NumValues; i++) byte_hist[i] = '0;
    held_count    = '0;
    scan_ptr      = '0;
    overflow_flag = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    ready_hold    = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = bsu_pkg::FuncStore;
    data_byte_i   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_sequences();
    test_backpressure();

    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("byte_sorter_unit: match");
    end else begin
      $display("byte_sorter_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("byte_sorter_unit: mismatch");
    $finish;
  end

endmodule
